// ----- hw/rtl/buddy_page_allocator_assert.svh -----
// assertion macros for the buddy page allocator
// the enclosing module provides clk and arst_n
`ifndef BUDDY_PAGE_ALLOCATOR_ASSERT_SVH
`define BUDDY_PAGE_ALLOCATOR_ASSERT_SVH
`ifndef SYNTHESIS
`define BPA_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("bpa: same-cycle check failed");
`define BPA_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("bpa: next-cycle check failed");
`else
`define BPA_ASSERT_IMP(label, ante, cons)
`define BPA_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// ----- hw/rtl/bpa_pkg.sv -----
package bpa_pkg;
	localparam int ADDR_W   = 48;
	localparam int CMD_W    = 2;
	localparam int ORDER_W  = 4;
	localparam int STATUS_W = 3;
	localparam int PAGES_W  = 11;
	localparam int WORD_W   = 32;
	localparam int BIT_W    = 5;

	localparam logic [CMD_W-1:0] CMD_INIT  = 2'd0;
	localparam logic [CMD_W-1:0] CMD_ALLOC = 2'd1;
	localparam logic [CMD_W-1:0] CMD_FREE  = 2'd2;

	localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
	localparam logic [STATUS_W-1:0] ST_OOM       = 3'd1;
	localparam logic [STATUS_W-1:0] ST_BAD_ORDER = 3'd2;
	localparam logic [STATUS_W-1:0] ST_BAD_ADDR  = 3'd3;
	localparam logic [STATUS_W-1:0] ST_DBL_FREE  = 3'd4;

	localparam logic CFG_POOL_BASE  = 1'b0;
	localparam logic CFG_POOL_PAGES = 1'b1;

	typedef struct packed {
		logic rd;
		logic we;
	} map_cmd_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [ADDR_W-1:0]   address;
	} result_t;
endpackage

// ----- hw/rtl/bpa_if.sv -----
interface bpa_in_if import bpa_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [CMD_W-1:0]   command;
	logic [ORDER_W-1:0] order;
	logic [ADDR_W-1:0]  block_address;
	modport source(output valid, command, order, block_address, input ready);
	modport sink(input valid, command, order, block_address, output ready);
endinterface

interface bpa_out_if import bpa_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [STATUS_W-1:0] status;
	logic [ADDR_W-1:0]   address;
	modport source(output valid, status, address, input ready);
	modport sink(input valid, status, address, output ready);
endinterface

// ----- hw/rtl/buddy_page_allocator.sv -----
// Buddy page allocator: init (command 0) clears the free map and carves pool_pages pages
// into the largest aligned power-of-two blocks, alloc (1) hands out the lowest free block
// of an order, splitting a larger one when needed, and free (2) returns a block and merges
// it upward with its buddy. Every command returns exactly one result item with a status
// and, for a good alloc, the byte address. The free map lives in one single-port memory of
// 32-bit rows, one bank of rows per order, and every bit change is a read then a write, so
// the rate is set by that port. After reset the block clears all 2**(ORD_W+ROW_W) map
// rows (512 at default parameters) before taking its first item; an init runs the same
// clearing pass, then steps down through the orders and reads then writes the row of each
// carved block. An alloc reads and checks each map row scanned (up to 68 rows when an
// order-0 request has to search every order), reads then writes a row per split and then
// forms the address; a free checks the address, reads and checks each overlap-scan row
// across all orders (11 at order 0 up to 68 at order 10) and rewrites a row per merge.
`include "buddy_page_allocator_assert.svh"
module buddy_page_allocator import bpa_pkg::*; #(
	parameter int NUM_ORDERS = 11,
	parameter int PAGE_BYTES = 4096,
	parameter int MAX_PAGES  = 1024
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [0:0]        cfg_index,
	input  logic [ADDR_W-1:0] cfg_wdata,
	bpa_in_if.sink            in_ch,
	bpa_out_if.source         out_ch
);
	// map geometry: one bank of rows per order, addressed {order, row}
	localparam int RPO    = (MAX_PAGES + WORD_W - 1) / WORD_W;
	localparam int ROW_W  = (RPO > 1) ? $clog2(RPO) : 1;
	localparam int ORD_W  = (NUM_ORDERS > 1) ? $clog2(NUM_ORDERS) : 1;
	localparam int MAP_AW = ORD_W + ROW_W;

	// configuration registers
	logic [ADDR_W-1:0]  pool_base_q;
	logic [PAGES_W-1:0] pool_pages_q;

	// map port wires, and result handoff between sequencer and output register
	map_cmd_t            map_cmd;
	logic [MAP_AW-1:0]   map_addr;
	logic [WORD_W-1:0]   map_wdata;
	logic [WORD_W-1:0]   map_rdata;
	logic [BIT_W-1:0]    map_low_bit;
	logic                res_valid;
	result_t             res;
	logic                res_take;

	// output register
	logic                out_valid_q;
	logic [STATUS_W-1:0] out_status_q;
	logic [ADDR_W-1:0]   out_address_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pool_base_q  <= '0;
			pool_pages_q <= PAGES_W'(1024);
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_POOL_BASE:  pool_base_q  <= cfg_wdata;
				CFG_POOL_PAGES: pool_pages_q <= cfg_wdata[PAGES_W-1:0];
				default:        pool_base_q  <= pool_base_q;
			endcase
		end
	end

	bpa_seq #(
		.NUM_ORDERS(NUM_ORDERS),
		.PAGE_BYTES(PAGE_BYTES),
		.MAX_PAGES (MAX_PAGES),
		.MEM_AW    (MAP_AW)
	) u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_ch      (in_ch),
		.pool_base  (pool_base_q),
		.pool_pages (pool_pages_q),
		.map_cmd    (map_cmd),
		.map_addr   (map_addr),
		.map_wdata  (map_wdata),
		.map_rdata  (map_rdata),
		.map_low_bit(map_low_bit),
		.res_valid  (res_valid),
		.res        (res),
		.res_take   (res_take)
	);

	bpa_map #(
		.AW(MAP_AW)
	) u_map (
		.clk    (clk),
		.cmd    (map_cmd),
		.addr   (map_addr),
		.wdata  (map_wdata),
		.rdata  (map_rdata),
		.low_bit(map_low_bit)
	);

	// the sequencer hands over its result whenever the output slot is free or draining
	assign res_take = res_valid && (!out_valid_q || out_ch.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_take) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_take) begin
			out_status_q  <= res.status;
			out_address_q <= res.address;
		end
	end

	assign out_ch.valid   = out_valid_q;
	assign out_ch.status  = out_status_q;
	assign out_ch.address = out_address_q;

	// one item at a time: after an accept the sequencer is busy
	`BPA_ASSERT_NEXT(a_busy_after_accept, in_ch.valid && in_ch.ready, !in_ch.ready)
	// a finished result waits unchanged until the output register takes it
	`BPA_ASSERT_NEXT(a_result_held, res_valid && !res_take, res_valid && $stable(res))
	`BPA_ASSERT_IMP(a_status_range, res_valid, res.status <= ST_DBL_FREE)
	// only a good alloc carries an address
	`BPA_ASSERT_IMP(a_addr_zero_on_err, res_valid && res.status != ST_OK, res.address == '0)
endmodule

// ----- hw/rtl/bpa_map.sv -----
module bpa_map import bpa_pkg::*; #(
	parameter int AW = 9
) (
	input  logic              clk,
	input  map_cmd_t          cmd,
	input  logic [AW-1:0]     addr,
	input  logic [WORD_W-1:0] wdata,
	output logic [WORD_W-1:0] rdata,
	output logic [BIT_W-1:0]  low_bit
);
	logic [WORD_W-1:0] mem_q [2**AW];
	logic [WORD_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (cmd.we)
			mem_q[addr] <= wdata;
		if (cmd.rd)
			rdata_q <= mem_q[addr];
	end

	// lowest set bit of the row just read
	always_comb begin
		low_bit = '0;
		for (int i = WORD_W - 1; i >= 0; i--) begin
			if (rdata_q[i])
				low_bit = BIT_W'(i);
		end
	end

	assign rdata = rdata_q;
endmodule

// ----- hw/rtl/bpa_seq.sv -----
module bpa_seq import bpa_pkg::*; #(
	parameter int NUM_ORDERS = 11,
	parameter int PAGE_BYTES = 4096,
	parameter int MAX_PAGES  = 1024,
	parameter int MEM_AW     = 9
) (
	input  logic               clk,
	input  logic               arst_n,
	bpa_in_if.sink             in_ch,
	input  logic [ADDR_W-1:0]  pool_base,
	input  logic [PAGES_W-1:0] pool_pages,
	output map_cmd_t           map_cmd,
	output logic [MEM_AW-1:0]  map_addr,
	output logic [WORD_W-1:0]  map_wdata,
	input  logic [WORD_W-1:0]  map_rdata,
	input  logic [BIT_W-1:0]   map_low_bit,
	output logic               res_valid,
	output result_t            res,
	input  logic               res_take
);
	localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
	localparam int IDX_W = $clog2(MAX_PAGES + 1);
	localparam int RPO   = (MAX_PAGES + WORD_W - 1) / WORD_W;
	localparam int ROW_W = (RPO > 1) ? $clog2(RPO) : 1;
	localparam int ORD_W = (NUM_ORDERS > 1) ? $clog2(NUM_ORDERS) : 1;
	localparam int RC_W  = ROW_W + 1;
	localparam logic [ORD_W-1:0] KTOP = ORD_W'(NUM_ORDERS - 1);
	localparam logic [31:0] MAXP = 32'(MAX_PAGES);

	localparam logic [3:0] S_CLEAR  = 4'd0;
	localparam logic [3:0] S_IDLE   = 4'd1;
	localparam logic [3:0] S_A_RD   = 4'd2;
	localparam logic [3:0] S_A_CHK  = 4'd3;
	localparam logic [3:0] S_S_RD   = 4'd4;
	localparam logic [3:0] S_S_WR   = 4'd5;
	localparam logic [3:0] S_ADDR   = 4'd6;
	localparam logic [3:0] S_F_SUB  = 4'd7;
	localparam logic [3:0] S_F_CHK  = 4'd8;
	localparam logic [3:0] S_O_RD   = 4'd9;
	localparam logic [3:0] S_O_CHK  = 4'd10;
	localparam logic [3:0] S_M_RD   = 4'd11;
	localparam logic [3:0] S_M_WR   = 4'd12;
	localparam logic [3:0] S_C_STEP = 4'd13;
	localparam logic [3:0] S_C_WR   = 4'd14;
	localparam logic [3:0] S_DONE   = 4'd15;

	logic [3:0]          state_q;
	logic [MEM_AW-1:0]   clr_q;
	logic                carve_q;
	logic [ORD_W-1:0]    k_q;
	logic [ORD_W-1:0]    ord_q;
	logic [ROW_W-1:0]    row_q;
	logic [RC_W-1:0]     rc_q;
	logic [IDX_W-1:0]    idx_q;
	logic [IDX_W-1:0]    off_q;
	logic [IDX_W-1:0]    left_q;
	logic [ADDR_W-1:0]   rel_q;
	logic [ADDR_W-1:0]   baddr_q;
	logic [STATUS_W-1:0] status_q;
	logic [ADDR_W-1:0]   address_q;

	logic [ADDR_W-1:0] page_base;
	logic [IDX_W-1:0]  eff;
	logic              bad_order;
	logic [31:0]       slots;
	logic [ROW_W-1:0]  a_last;
	logic [IDX_W-1:0]  sidx;
	logic [IDX_W-1:0]  start;
	logic              j_ge;
	logic [ORD_W-1:0]  d;
	logic [RC_W-1:0]   ov_last;
	logic [ROW_W-1:0]  ov_row;
	logic [WORD_W-1:0] ones;
	logic [WORD_W-1:0] ov_mask;
	logic [IDX_W-1:0]  rel_low;
	logic              rel_hi;
	logic              f_bad;
	logic [BIT_W-1:0]  m_pos;
	logic              m_merge;
	logic [31:0]       sz32;
	logic              c_fit;
	logic [IDX_W-1:0]  cidx;

	assign page_base = pool_base & ~((ADDR_W'(1) << PAGE_SHIFT) - ADDR_W'(1));
	assign eff = (32'(pool_pages) > MAXP) ? IDX_W'(MAX_PAGES) : IDX_W'(pool_pages);
	assign bad_order = 32'(in_ch.order) >= 32'(NUM_ORDERS);

	// alloc scan bound per order
	assign slots  = MAXP >> k_q;
	assign a_last = (slots == 32'd0) ? '0 : ROW_W'((slots - 32'd1) >> BIT_W);
	assign sidx   = (idx_q << 1) | IDX_W'(1);

	// overlap window of the freed block at level k_q
	assign start   = off_q >> k_q;
	assign j_ge    = k_q >= ord_q;
	assign d       = ord_q - k_q;
	assign ov_last = (j_ge || 32'(d) < 32'd5) ? '0
	               : RC_W'((32'd1 << (32'(d) - 32'd5)) - 32'd1);
	assign ov_row  = ROW_W'(start >> BIT_W) + ROW_W'(rc_q);

	always_comb begin
		if (j_ge) begin
			ones = WORD_W'(1);
		end else begin
			case (32'(d))
				32'd0:   ones = 32'h0000_0001;
				32'd1:   ones = 32'h0000_0003;
				32'd2:   ones = 32'h0000_000f;
				32'd3:   ones = 32'h0000_00ff;
				32'd4:   ones = 32'h0000_ffff;
				default: ones = 32'hffff_ffff;
			endcase
		end
	end
	assign ov_mask = (!j_ge && 32'(d) >= 32'd5) ? ones : (ones << BIT_W'(start));

	assign rel_low = rel_q[PAGE_SHIFT +: IDX_W];
	assign rel_hi  = (rel_q >> (PAGE_SHIFT + IDX_W)) != '0;
	assign f_bad   = (rel_q[PAGE_SHIFT-1:0] != '0) || rel_hi || (rel_low >= eff)
	              || ((rel_low & IDX_W'((32'd1 << ord_q) - 32'd1)) != '0)
	              || ((32'(rel_low) + (32'd1 << ord_q)) > 32'(eff));

	assign m_pos   = BIT_W'(idx_q);
	assign m_merge = (k_q != KTOP) && map_rdata[m_pos ^ BIT_W'(1)];

	assign sz32  = 32'd1 << k_q;
	assign c_fit = 32'(left_q) >= sz32;
	assign cidx  = off_q >> k_q;

	always_comb begin
		map_cmd   = '0;
		map_addr  = '0;
		map_wdata = '0;
		unique case (state_q)
			S_CLEAR: begin
				map_cmd.we = 1'b1;
				map_addr   = clr_q;
			end
			S_A_RD: begin
				map_cmd.rd = 1'b1;
				map_addr   = {k_q, row_q};
			end
			S_A_CHK: begin
				map_cmd.we = |map_rdata;
				map_addr   = {k_q, row_q};
				map_wdata  = map_rdata & ~(WORD_W'(1) << map_low_bit);
			end
			S_S_RD: begin
				map_cmd.rd = 1'b1;
				map_addr   = {k_q - ORD_W'(1), ROW_W'(sidx >> BIT_W)};
			end
			S_S_WR: begin
				map_cmd.we = 1'b1;
				map_addr   = {k_q, ROW_W'((idx_q | IDX_W'(1)) >> BIT_W)};
				map_wdata  = map_rdata | (WORD_W'(1) << BIT_W'(idx_q | IDX_W'(1)));
			end
			S_O_RD: begin
				map_cmd.rd = 1'b1;
				map_addr   = {k_q, ov_row};
			end
			S_M_RD: begin
				map_cmd.rd = 1'b1;
				map_addr   = {k_q, ROW_W'(idx_q >> BIT_W)};
			end
			S_M_WR: begin
				map_cmd.we = 1'b1;
				map_addr   = {k_q, ROW_W'(idx_q >> BIT_W)};
				map_wdata  = m_merge ? (map_rdata & ~(WORD_W'(1) << (m_pos ^ BIT_W'(1))))
				                     : (map_rdata | (WORD_W'(1) << m_pos));
			end
			S_C_STEP: begin
				map_cmd.rd = c_fit;
				map_addr   = {k_q, ROW_W'(cidx >> BIT_W)};
			end
			S_C_WR: begin
				map_cmd.we = 1'b1;
				map_addr   = {k_q, ROW_W'(cidx >> BIT_W)};
				map_wdata  = map_rdata | (WORD_W'(1) << BIT_W'(cidx));
			end
			default: begin
				map_cmd = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_CLEAR;
			clr_q     <= '0;
			carve_q   <= 1'b0;
			k_q       <= '0;
			ord_q     <= '0;
			row_q     <= '0;
			rc_q      <= '0;
			idx_q     <= '0;
			off_q     <= '0;
			left_q    <= '0;
			rel_q     <= '0;
			baddr_q   <= '0;
			status_q  <= ST_OK;
			address_q <= '0;
		end else begin
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + MEM_AW'(1);
					if (&clr_q) begin
						if (carve_q) begin
							k_q    <= KTOP;
							off_q  <= '0;
							left_q <= eff;
							state_q <= S_C_STEP;
						end else begin
							state_q <= S_IDLE;
						end
					end
				end
				S_IDLE: begin
					if (in_ch.valid) begin
						status_q  <= ST_OK;
						address_q <= '0;
						baddr_q   <= in_ch.block_address;
						ord_q     <= ORD_W'(in_ch.order);
						k_q       <= ORD_W'(in_ch.order);
						row_q     <= '0;
						rc_q      <= '0;
						case (in_ch.command)
							CMD_INIT: begin
								carve_q <= 1'b1;
								state_q <= S_CLEAR;
							end
							CMD_ALLOC: begin
								if (bad_order) begin
									status_q <= ST_BAD_ORDER;
									state_q  <= S_DONE;
								end else begin
									state_q <= S_A_RD;
								end
							end
							CMD_FREE: begin
								if (bad_order) begin
									status_q <= ST_BAD_ORDER;
									state_q  <= S_DONE;
								end else begin
									state_q <= S_F_SUB;
								end
							end
							default: begin
								state_q <= S_DONE;
							end
						endcase
					end
				end
				S_A_RD: begin
					state_q <= S_A_CHK;
				end
				S_A_CHK: begin
					if (|map_rdata) begin
						idx_q   <= IDX_W'({row_q, map_low_bit});
						state_q <= (k_q == ord_q) ? S_ADDR : S_S_RD;
					end else if (row_q == a_last) begin
						if (k_q == KTOP) begin
							status_q <= ST_OOM;
							state_q  <= S_DONE;
						end else begin
							k_q     <= k_q + ORD_W'(1);
							row_q   <= '0;
							state_q <= S_A_RD;
						end
					end else begin
						row_q   <= row_q + ROW_W'(1);
						state_q <= S_A_RD;
					end
				end
				S_S_RD: begin
					k_q     <= k_q - ORD_W'(1);
					idx_q   <= idx_q << 1;
					state_q <= S_S_WR;
				end
				S_S_WR: begin
					state_q <= (k_q == ord_q) ? S_ADDR : S_S_RD;
				end
				S_ADDR: begin
					address_q <= page_base + (ADDR_W'(idx_q << ord_q) << PAGE_SHIFT);
					state_q   <= S_DONE;
				end
				S_F_SUB: begin
					rel_q <= baddr_q - page_base;
					if (baddr_q < page_base) begin
						status_q <= ST_BAD_ADDR;
						state_q  <= S_DONE;
					end else begin
						state_q <= S_F_CHK;
					end
				end
				S_F_CHK: begin
					if (f_bad) begin
						status_q <= ST_BAD_ADDR;
						state_q  <= S_DONE;
					end else begin
						off_q   <= rel_low;
						k_q     <= '0;
						rc_q    <= '0;
						state_q <= S_O_RD;
					end
				end
				S_O_RD: begin
					state_q <= S_O_CHK;
				end
				S_O_CHK: begin
					if (|(map_rdata & ov_mask)) begin
						status_q <= ST_DBL_FREE;
						state_q  <= S_DONE;
					end else if (rc_q != ov_last) begin
						rc_q    <= rc_q + RC_W'(1);
						state_q <= S_O_RD;
					end else if (k_q == KTOP) begin
						k_q     <= ord_q;
						idx_q   <= off_q >> ord_q;
						state_q <= S_M_RD;
					end else begin
						k_q     <= k_q + ORD_W'(1);
						rc_q    <= '0;
						state_q <= S_O_RD;
					end
				end
				S_M_RD: begin
					state_q <= S_M_WR;
				end
				S_M_WR: begin
					if (m_merge) begin
						idx_q   <= idx_q >> 1;
						k_q     <= k_q + ORD_W'(1);
						state_q <= S_M_RD;
					end else begin
						state_q <= S_DONE;
					end
				end
				S_C_STEP: begin
					if (c_fit) begin
						state_q <= S_C_WR;
					end else if (k_q == '0) begin
						carve_q <= 1'b0;
						state_q <= S_DONE;
					end else begin
						k_q <= k_q - ORD_W'(1);
					end
				end
				S_C_WR: begin
					off_q   <= off_q + IDX_W'(sz32);
					left_q  <= left_q - IDX_W'(sz32);
					state_q <= S_C_STEP;
				end
				S_DONE: begin
					if (res_take)
						state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign in_ch.ready = state_q == S_IDLE;
	assign res_valid   = state_q == S_DONE;
	assign res.status  = status_q;
	assign res.address = address_q;
endmodule
